### sv/gap_filling_frame_ring_writer_core_defines.svh
// Assertion macros for the frame ring writer
`ifndef GAP_FILLING_FRAME_RING_WRITER_CORE_DEFINES_SVH
`define GAP_FILLING_FRAME_RING_WRITER_CORE_DEFINES_SVH

// same-cycle implication
`define GFW_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define GFW_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/gfw_pkg.sv
// Types and constants shared by the frame ring writer modules
package gfw_pkg;

    localparam int CFG_W      = 17;
    localparam int CFG_IDX_W  = 2;
    localparam int PS_W       = 13;
    localparam int SAMPLE_W   = 16;
    localparam int SEQ_W      = 32;
    localparam int ADDR_W     = 16;
    localparam int FIDX_W     = 16;
    localparam int OFF_W      = 16;
    localparam int CNT_W      = 18;
    localparam int DIV_NW     = SEQ_W + PS_W;
    localparam int DIV_DW     = CFG_W;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_LENGTH   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RING_LENGTH    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PACKET_SAMPLES = 2'd2;

    localparam logic [CFG_W-1:0] FRAME_LENGTH_RESET   = 17'd4096;
    localparam logic [CFG_W-1:0] RING_LENGTH_RESET    = 17'd65536;
    localparam logic [PS_W-1:0]  PACKET_SAMPLES_RESET = 13'd728;
    localparam logic [CFG_W-1:0] FRAME_MAX            = 17'd65536;

    localparam logic OP_PUSH    = 1'b0;
    localparam logic OP_READ    = 1'b1;
    localparam logic KIND_FRAME = 1'b0;
    localparam logic KIND_READ  = 1'b1;

    typedef struct packed {
        logic                       operation;
        logic signed [SAMPLE_W-1:0] sample;
        logic [SEQ_W-1:0]           packet_seq;
        logic                       packet_start;
        logic [ADDR_W-1:0]          read_address;
    } t_item;

    typedef struct packed {
        logic                       kind;
        logic [FIDX_W-1:0]          frame_index;
        logic signed [SAMPLE_W-1:0] read_value;
        logic                       last;
    } t_result;

endpackage

### sv/gfw_div.sv
// Restoring divider, one quotient bit per cycle
module gfw_div (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [gfw_pkg::DIV_NW-1:0]     i_dividend,
    input  logic [gfw_pkg::DIV_DW-1:0]     i_divisor,
    output logic                           o_done,
    output logic [gfw_pkg::DIV_NW-1:0]     o_quotient,
    output logic [gfw_pkg::DIV_DW-1:0]     o_remainder
);

    localparam int NW  = gfw_pkg::DIV_NW;
    localparam int DW  = gfw_pkg::DIV_DW;
    localparam int CW  = $clog2(NW + 1);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [NW-1:0] r_quo;
    logic [DW-1:0] r_rem;
    logic [DW-1:0] r_div;

    logic [DW:0]   rem_sh;
    logic          fits;
    logic [DW-1:0] n_rem;

    always_comb begin
        rem_sh = {r_rem, r_quo[NW-1]};
        fits   = rem_sh >= {1'b0, r_div};
        n_rem  = fits ? DW'(rem_sh - {1'b0, r_div}) : DW'(rem_sh);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(NW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[NW-2:0], fits};
            r_rem <= n_rem;
        end
    end

    assign o_done      = r_done;
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;

endmodule

### sv/gfw_mem.sv
// Sample store: one write port, one registered read port
module gfw_mem #(
    parameter int DEPTH = 65536,
    parameter int AW    = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_we,
    input  logic [AW-1:0]                        i_waddr,
    input  logic signed [gfw_pkg::SAMPLE_W-1:0]  i_wdata,
    input  logic                                 i_re,
    input  logic [gfw_pkg::ADDR_W-1:0]           i_raddr,
    output logic signed [gfw_pkg::SAMPLE_W-1:0]  o_rdata
);

    localparam int CW = ((AW > gfw_pkg::ADDR_W) ? AW : gfw_pkg::ADDR_W) + 1;

    logic signed [gfw_pkg::SAMPLE_W-1:0] mem [DEPTH];
    logic signed [gfw_pkg::SAMPLE_W-1:0] r_rdata;
    logic                                r_zero;

    logic [CW-1:0] raddr_ext;
    logic          in_range;
    logic [AW-1:0] ridx;

    always_comb begin
        raddr_ext = CW'(i_raddr);
        in_range  = raddr_ext < CW'(DEPTH);
        ridx      = raddr_ext[AW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= mem[ridx];
            r_zero  <= !in_range;
        end
    end

    assign o_rdata = r_zero ? '0 : r_rdata;

endmodule

### sv/gap_filling_frame_ring_writer_core.sv
// Frame ring writer top level: control sequencer, config registers, store and divider
//
// Usage: write frame_length, ring_length and packet_samples on the config channel
// (i_cfg_valid / o_cfg_ready, index and data) while busy is low. Items enter when
// start is high and busy is low. A read item returns its stored word via the
// store's read register and the result register. A push without padding passes
// the pad check and sample states; any frame report appears on o_strobe in the
// cycle busy falls. A packet start with a sequence gap adds the multiply and
// compare states, a remainder division on the shared serial divider when the gap
// spans a frame end, and a store write per zeroed entry. The first push after a
// frame_length or ring_length write re-derives the frame offset with the divider.
// A push yields up to two frame reports on consecutive cycles, the final one with
// last set. Results are shown for one cycle; the receiver cannot stall them.
// Reset restores the register defaults, clears the write position, the sequence
// history and the sequencer; the store contents are not cleared.
`include "gap_filling_frame_ring_writer_core_defines.svh"

module gap_filling_frame_ring_writer_core #(
    parameter int RING_DEPTH = 65536
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [gfw_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [gfw_pkg::CFG_W-1:0]         i_cfg_data,
    input  logic                              start,
    output logic                              busy,
    input  gfw_pkg::t_item                    i_item,
    output logic                              o_strobe,
    output gfw_pkg::t_result                  o_result
);

    localparam int AW = $clog2(RING_DEPTH);
    localparam int RW = ((AW + 1) > gfw_pkg::CFG_W) ? (AW + 1) : gfw_pkg::CFG_W;

    typedef enum logic [3:0] {
        S_IDLE,
        S_NORM,
        S_PAD_CHK,
        S_PAD_MUL,
        S_PAD_CMP,
        S_PAD_DIV,
        S_ZERO,
        S_SAMPLE,
        S_EMIT2,
        S_READ
    } t_state;

    t_state                          r_state;
    logic                            r_strobe;
    logic [AW-1:0]                   r_wp;
    logic [gfw_pkg::OFF_W-1:0]       r_off;
    logic [AW-1:0]                   r_idx;
    logic [gfw_pkg::SEQ_W-1:0]       r_last_seq;
    logic                            r_seen;
    logic                            r_dirty;
    logic [gfw_pkg::CFG_W-1:0]       r_cfg_f;
    logic [gfw_pkg::CFG_W-1:0]       r_cfg_r;
    logic [gfw_pkg::PS_W-1:0]        r_cfg_ps;
    logic [gfw_pkg::CNT_W-1:0]       r_cnt;
    logic                            r_pad_rep;

    gfw_pkg::t_item                  r_item;
    logic [gfw_pkg::SEQ_W-1:0]       r_gap;
    logic [gfw_pkg::DIV_NW-1:0]      r_zeros;
    logic [gfw_pkg::FIDX_W-1:0]      r_pad_frame;
    logic [gfw_pkg::FIDX_W-1:0]      r_samp_frame;
    gfw_pkg::t_result                r_result;

    logic [gfw_pkg::CFG_W-1:0]       f_eff;
    logic [RW-1:0]                   ring_ext;
    logic [AW:0]                     ring_eff;
    logic                            wp_beyond;
    logic                            off_ok;
    logic [AW-1:0]                   p_norm;
    logic [AW:0]                     p_inc;
    logic [gfw_pkg::CFG_W-1:0]       off_inc;
    logic                            adv_wrap;
    logic                            adv_fend;
    logic                            adv_done;
    logic [AW-1:0]                   n_wp;
    logic [gfw_pkg::OFF_W-1:0]       n_off;
    logic [AW-1:0]                   n_idx;
    logic [gfw_pkg::CFG_W-1:0]       to_end;
    logic                            zeros_lt;
    logic                            pad_cond;
    logic                            accept;

    logic                            div_start;
    logic [gfw_pkg::DIV_NW-1:0]      div_dividend;
    logic                            div_done;
    logic [gfw_pkg::DIV_NW-1:0]      div_quo;
    logic [gfw_pkg::DIV_DW-1:0]      div_rem;

    logic                                mem_we;
    logic signed [gfw_pkg::SAMPLE_W-1:0] mem_wdata;
    logic                                mem_re;
    logic signed [gfw_pkg::SAMPLE_W-1:0] mem_rdata;

    always_comb begin
        if (r_cfg_f == '0) begin
            f_eff = gfw_pkg::CFG_W'(1);
        end else if (r_cfg_f > gfw_pkg::FRAME_MAX) begin
            f_eff = gfw_pkg::FRAME_MAX;
        end else begin
            f_eff = r_cfg_f;
        end

        ring_ext = RW'(r_cfg_r);
        if (ring_ext == '0) begin
            ring_eff = (AW + 1)'(1);
        end else if (ring_ext > RW'(RING_DEPTH)) begin
            ring_eff = (AW + 1)'(RING_DEPTH);
        end else begin
            ring_eff = (AW + 1)'(ring_ext);
        end

        wp_beyond = {1'b0, r_wp} >= ring_eff;
        off_ok    = {1'b0, r_off} < f_eff;
        p_norm    = wp_beyond ? '0 : r_wp;

        p_inc    = {1'b0, r_wp} + (AW + 1)'(1);
        off_inc  = {1'b0, r_off} + gfw_pkg::CFG_W'(1);
        adv_wrap = p_inc >= ring_eff;
        adv_fend = off_inc == f_eff;
        adv_done = adv_wrap || adv_fend;

        n_wp  = p_inc[AW-1:0];
        n_off = off_inc[gfw_pkg::OFF_W-1:0];
        n_idx = r_idx;
        if (adv_wrap) begin
            n_wp  = '0;
            n_off = '0;
            n_idx = '0;
        end else if (adv_fend) begin
            n_off = '0;
            n_idx = r_idx + AW'(1);
        end

        to_end   = f_eff - {1'b0, r_off};
        zeros_lt = r_zeros < gfw_pkg::DIV_NW'(to_end);
        pad_cond = r_item.packet_start && r_seen &&
                   ({1'b0, r_item.packet_seq} > ({1'b0, r_last_seq} + 33'd1));

        accept = start && !busy;

        div_start    = 1'b0;
        div_dividend = r_zeros - gfw_pkg::DIV_NW'(to_end);
        if (r_state == S_IDLE) begin
            div_start    = accept && (i_item.operation == gfw_pkg::OP_PUSH) && r_dirty;
            div_dividend = gfw_pkg::DIV_NW'(p_norm);
        end else if (r_state == S_PAD_CMP) begin
            div_start = !zeros_lt;
        end

        mem_we    = ((r_state == S_ZERO) && (r_cnt != '0)) || (r_state == S_SAMPLE);
        mem_wdata = (r_state == S_SAMPLE) ? r_item.sample : '0;
        mem_re    = accept && (i_item.operation == gfw_pkg::OP_READ);
    end

    assign busy        = (r_state != S_IDLE);
    assign o_cfg_ready = (r_state == S_IDLE);
    assign o_strobe    = r_strobe;
    assign o_result    = r_result;

    gfw_div u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (div_start),
        .i_dividend  (div_dividend),
        .i_divisor   (f_eff),
        .o_done      (div_done),
        .o_quotient  (div_quo),
        .o_remainder (div_rem)
    );

    gfw_mem #(
        .DEPTH (RING_DEPTH),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (r_wp),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (i_item.read_address),
        .o_rdata (mem_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_strobe   <= 1'b0;
            r_wp       <= '0;
            r_off      <= '0;
            r_idx      <= '0;
            r_last_seq <= '0;
            r_seen     <= 1'b0;
            r_dirty    <= 1'b0;
            r_cfg_f    <= gfw_pkg::FRAME_LENGTH_RESET;
            r_cfg_r    <= gfw_pkg::RING_LENGTH_RESET;
            r_cfg_ps   <= gfw_pkg::PACKET_SAMPLES_RESET;
            r_cnt      <= '0;
            r_pad_rep  <= 1'b0;
        end else begin
            r_strobe <= 1'b0;
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    gfw_pkg::REG_FRAME_LENGTH: begin
                        r_cfg_f <= i_cfg_data;
                        r_dirty <= 1'b1;
                    end
                    gfw_pkg::REG_RING_LENGTH: begin
                        r_cfg_r <= i_cfg_data;
                        r_dirty <= 1'b1;
                    end
                    gfw_pkg::REG_PACKET_SAMPLES: begin
                        r_cfg_ps <= i_cfg_data[gfw_pkg::PS_W-1:0];
                    end
                    default: ;
                endcase
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        if (i_item.operation == gfw_pkg::OP_READ) begin
                            r_state <= S_READ;
                        end else if (r_dirty) begin
                            r_wp    <= p_norm;
                            r_state <= S_NORM;
                        end else begin
                            r_state <= S_PAD_CHK;
                        end
                    end
                end
                S_NORM: begin
                    if (div_done) begin
                        r_off   <= div_rem[gfw_pkg::OFF_W-1:0];
                        r_idx   <= div_quo[AW-1:0];
                        r_dirty <= 1'b0;
                        r_state <= S_PAD_CHK;
                    end
                end
                S_PAD_CHK: begin
                    r_pad_rep <= 1'b0;
                    if (r_item.packet_start) begin
                        r_last_seq <= r_item.packet_seq;
                        r_seen     <= 1'b1;
                    end
                    r_state <= pad_cond ? S_PAD_MUL : S_SAMPLE;
                end
                S_PAD_MUL: begin
                    r_state <= S_PAD_CMP;
                end
                S_PAD_CMP: begin
                    if (zeros_lt) begin
                        r_cnt   <= gfw_pkg::CNT_W'(r_zeros);
                        r_state <= S_ZERO;
                    end else begin
                        r_cnt     <= gfw_pkg::CNT_W'(to_end);
                        r_pad_rep <= 1'b1;
                        r_state   <= S_PAD_DIV;
                    end
                end
                S_PAD_DIV: begin
                    if (div_done) begin
                        r_cnt   <= r_cnt + gfw_pkg::CNT_W'(div_rem);
                        r_state <= S_ZERO;
                    end
                end
                S_ZERO: begin
                    if (r_cnt == '0) begin
                        r_state <= S_SAMPLE;
                    end else begin
                        r_cnt <= r_cnt - gfw_pkg::CNT_W'(1);
                        r_wp  <= n_wp;
                        r_off <= n_off;
                        r_idx <= n_idx;
                        if (adv_wrap) begin
                            r_pad_rep <= 1'b1;
                        end
                    end
                end
                S_SAMPLE: begin
                    r_wp  <= n_wp;
                    r_off <= n_off;
                    r_idx <= n_idx;
                    if (r_pad_rep) begin
                        r_strobe <= 1'b1;
                        r_state  <= adv_done ? S_EMIT2 : S_IDLE;
                    end else begin
                        r_strobe <= adv_done;
                        r_state  <= S_IDLE;
                    end
                end
                S_EMIT2: begin
                    r_strobe <= 1'b1;
                    r_state  <= S_IDLE;
                end
                S_READ: begin
                    r_strobe <= 1'b1;
                    r_state  <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    r_item <= i_item;
                end
            end
            S_PAD_CHK: begin
                r_gap <= r_item.packet_seq - r_last_seq - gfw_pkg::SEQ_W'(1);
            end
            S_PAD_MUL: begin
                r_zeros <= gfw_pkg::DIV_NW'(r_gap) * gfw_pkg::DIV_NW'(r_cfg_ps);
            end
            S_PAD_CMP: begin
                r_pad_frame <= gfw_pkg::FIDX_W'(r_idx);
            end
            S_SAMPLE: begin
                r_samp_frame         <= gfw_pkg::FIDX_W'(r_idx);
                r_result.kind        <= gfw_pkg::KIND_FRAME;
                r_result.read_value  <= '0;
                if (r_pad_rep) begin
                    r_result.frame_index <= r_pad_frame;
                    r_result.last        <= !adv_done;
                end else begin
                    r_result.frame_index <= gfw_pkg::FIDX_W'(r_idx);
                    r_result.last        <= 1'b1;
                end
            end
            S_EMIT2: begin
                r_result.kind        <= gfw_pkg::KIND_FRAME;
                r_result.frame_index <= r_samp_frame;
                r_result.read_value  <= '0;
                r_result.last        <= 1'b1;
            end
            S_READ: begin
                r_result.kind        <= gfw_pkg::KIND_READ;
                r_result.frame_index <= '0;
                r_result.read_value  <= mem_rdata;
                r_result.last        <= 1'b1;
            end
            default: ;
        endcase
    end

    `GFW_ASSERT_NOW(a_wp_in_ring, i_clk, i_rst_n,
        (r_state == S_ZERO || r_state == S_SAMPLE), !wp_beyond,
        "write position outside ring while writing")
    `GFW_ASSERT_NOW(a_off_in_frame, i_clk, i_rst_n,
        (r_state == S_ZERO || r_state == S_SAMPLE), off_ok,
        "frame offset not below frame length")
    `GFW_ASSERT_NOW(a_div_expected, i_clk, i_rst_n,
        div_done, (r_state == S_NORM || r_state == S_PAD_DIV),
        "divider finished with no division pending")
    `GFW_ASSERT_NEXT(a_read_result, i_clk, i_rst_n,
        (r_state == S_READ), (o_strobe && o_result.kind == gfw_pkg::KIND_READ),
        "read item gave no read result")
    `GFW_ASSERT_NEXT(a_pair_follows, i_clk, i_rst_n,
        (o_strobe && !o_result.last), o_strobe,
        "first of two results not followed by second")

endmodule

### sim/gap_filling_frame_ring_writer_core_tb.sv
// Self-checking testbench for the gap-filling frame ring writer: directed table, then random packets
module gap_filling_frame_ring_writer_core_tb;

    localparam int CYCLE_LIMIT = 3000000;
    localparam int SETTLE_CYCLES = 64;
    localparam int RANDOM_PHASES = 10;
    localparam int ITEMS_PER_PHASE = 100;
    localparam int STORE_DEPTH = 65536;

    typedef struct {
        bit                                is_cfg;
        logic [gfw_pkg::CFG_W-1:0]         fl;
        logic [gfw_pkg::CFG_W-1:0]         rl;
        logic [gfw_pkg::PS_W-1:0]          ps;
        gfw_pkg::t_item                    it;
        bit                                typed;
        int                                typed_n;
        gfw_pkg::t_result                  typed_r;
    } t_plan_row;

    logic             i_clk = 1'b0;
    logic             i_rst_n;
    logic             i_cfg_valid;
    logic             o_cfg_ready;
    logic [gfw_pkg::CFG_IDX_W-1:0] i_cfg_index;
    logic [gfw_pkg::CFG_W-1:0] i_cfg_data;
    logic             start;
    logic             busy;
    gfw_pkg::t_item   i_item;
    logic             o_strobe;
    gfw_pkg::t_result o_result;

    // predictor state
    logic signed [gfw_pkg::SAMPLE_W-1:0] ring_mem [0:STORE_DEPTH-1];
    bit               ever_set [0:STORE_DEPTH-1];
    int unsigned      filled_addrs [$];
    int unsigned      wr_pos;
    logic [gfw_pkg::SEQ_W-1:0] last_seq;
    bit               seq_seen;
    logic [gfw_pkg::CFG_W-1:0] frame_len;
    logic [gfw_pkg::CFG_W-1:0] ring_len;
    logic [gfw_pkg::PS_W-1:0]  pkt_len;

    gfw_pkg::t_result owed [$];
    t_plan_row        plan [$];
    bit               no_gaps;
    int               errors;
    int               cycles;
    int               pushes_sent;
    int               reads_sent;
    int               reports_seen;
    int               words_seen;
    int               cfg_writes;
    gfw_pkg::t_result want;

    gap_filling_frame_ring_writer_core u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .start       (start),
        .busy        (busy),
        .i_item      (i_item),
        .o_strobe    (o_strobe),
        .o_result    (o_result)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("%0t: timeout, %0d results still outstanding", $time, owed.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    function automatic void field_check(string name, logic [31:0] exp_v, logic [31:0] got_v);
        if (got_v !== exp_v) begin
            errors++;
            $display("%0t: %s mismatch, expected %h, got %h", $time, name, exp_v, got_v);
        end
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_strobe === 1'b1) begin
            if (owed.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, expected none, got %h", $time, o_result);
            end else begin
                want = owed.pop_front();
                field_check("kind", 32'(want.kind), 32'(o_result.kind));
                field_check("frame_index", 32'(want.frame_index), 32'(o_result.frame_index));
                field_check("read_value", 32'(want.read_value), 32'(o_result.read_value));
                field_check("last", 32'(want.last), 32'(o_result.last));
                if (want.kind == gfw_pkg::KIND_FRAME) reports_seen++;
                else words_seen++;
            end
        end
    end

    function automatic int unsigned eff_len(logic [gfw_pkg::CFG_W-1:0] v);
        if (v == '0) return 1;
        if (v > gfw_pkg::FRAME_MAX) return 65536;
        return 32'(v);
    endfunction

    function automatic void put_cell(int unsigned a, logic signed [gfw_pkg::SAMPLE_W-1:0] v);
        ring_mem[a] = v;
        if (!ever_set[a]) begin
            ever_set[a] = 1'b1;
            filled_addrs.push_back(a);
        end
    endfunction

    task automatic ring_predict(input gfw_pkg::t_item it, output int n,
                                output gfw_pkg::t_result r0, output gfw_pkg::t_result r1);
        int unsigned rng;
        int unsigned frm;
        int unsigned pos;
        int unsigned frame_at;
        longint unsigned zeros;
        longint unsigned to_end;
        longint unsigned run_len;
        longint unsigned c;
        bit wrapped;
        bit done;
        gfw_pkg::t_result rep;
        n = 0;
        r0 = '0;
        r1 = '0;
        if (it.operation == gfw_pkg::OP_READ) begin
            r0.kind = gfw_pkg::KIND_READ;
            r0.read_value = ring_mem[it.read_address];
            r0.last = 1'b1;
            n = 1;
            return;
        end
        rng = eff_len(ring_len);
        frm = eff_len(frame_len);
        pos = wr_pos;
        if (pos >= rng) pos = 0;
        if (it.packet_start) begin
            if (seq_seen && {1'b0, it.packet_seq} > {1'b0, last_seq} + 33'd1) begin
                zeros = 64'(it.packet_seq - last_seq - 32'd1) * 64'(pkt_len);
                to_end = 64'(frm - pos % frm);
                frame_at = pos / frm;
                wrapped = 1'b0;
                run_len = (zeros < to_end) ? zeros : to_end + (zeros - to_end) % 64'(frm);
                for (c = 0; c < run_len; c++) begin
                    put_cell(pos, '0);
                    pos++;
                    if (pos >= rng) begin
                        pos = 0;
                        wrapped = 1'b1;
                    end
                end
                if (zeros >= to_end || wrapped) begin
                    rep = '0;
                    rep.kind = gfw_pkg::KIND_FRAME;
                    rep.frame_index = frame_at[gfw_pkg::FIDX_W-1:0];
                    r0 = rep;
                    n = 1;
                end
            end
            last_seq = it.packet_seq;
            seq_seen = 1'b1;
        end
        frame_at = pos / frm;
        put_cell(pos, it.sample);
        pos++;
        done = (pos % frm == 0);
        if (pos >= rng) begin
            pos = 0;
            done = 1'b1;
        end
        if (done) begin
            rep = '0;
            rep.kind = gfw_pkg::KIND_FRAME;
            rep.frame_index = frame_at[gfw_pkg::FIDX_W-1:0];
            if (n == 0) r0 = rep;
            else r1 = rep;
            n++;
        end
        wr_pos = pos;
        if (n == 2) r1.last = 1'b1;
        else if (n == 1) r0.last = 1'b1;
    endtask

    task automatic await_idle();
        start <= 1'b0;
        while (owed.size() != 0) @(posedge i_clk);
        while (busy !== 1'b0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_regs(input logic [gfw_pkg::CFG_W-1:0] fl,
                              input logic [gfw_pkg::CFG_W-1:0] rl,
                              input logic [gfw_pkg::PS_W-1:0] ps);
        int k;
        i_cfg_valid <= 1'b1;
        for (k = 0; k < 3; k++) begin
            case (k)
                0: begin
                    i_cfg_index <= gfw_pkg::REG_FRAME_LENGTH;
                    i_cfg_data <= fl;
                end
                1: begin
                    i_cfg_index <= gfw_pkg::REG_RING_LENGTH;
                    i_cfg_data <= rl;
                end
                default: begin
                    i_cfg_index <= gfw_pkg::REG_PACKET_SAMPLES;
                    i_cfg_data <= gfw_pkg::CFG_W'(ps);
                end
            endcase
            do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
            cfg_writes++;
        end
        i_cfg_valid <= 1'b0;
        frame_len = fl;
        ring_len = rl;
        pkt_len = ps;
    endtask

    task automatic send_item(input gfw_pkg::t_item it, input bit typed, input int typed_n,
                             input gfw_pkg::t_result typed_r);
        int n;
        gfw_pkg::t_result a;
        gfw_pkg::t_result b;
        if (!no_gaps && $urandom_range(99) < 21) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
        i_item <= it;
        start <= 1'b1;
        do @(posedge i_clk); while (busy !== 1'b0);
        ring_predict(it, n, a, b);
        if (typed) begin
            n = typed_n;
            a = typed_r;
        end
        if (n > 0) owed.push_back(a);
        if (n > 1) owed.push_back(b);
        if (it.operation == gfw_pkg::OP_READ) reads_sent++;
        else pushes_sent++;
    endtask

    task automatic add_push(input logic [gfw_pkg::SAMPLE_W-1:0] s,
                            input logic [gfw_pkg::SEQ_W-1:0] seq,
                            input bit first, input bit typed_none);
        t_plan_row row;
        row = '{default: '0};
        row.it.operation = gfw_pkg::OP_PUSH;
        row.it.sample = s;
        row.it.packet_seq = seq;
        row.it.packet_start = first;
        row.typed = typed_none;
        plan.push_back(row);
    endtask

    task automatic add_read(input logic [gfw_pkg::ADDR_W-1:0] addr, input bit typed,
                            input logic [gfw_pkg::SAMPLE_W-1:0] val);
        t_plan_row row;
        row = '{default: '0};
        row.it.operation = gfw_pkg::OP_READ;
        row.it.read_address = addr;
        row.typed = typed;
        row.typed_n = 1;
        row.typed_r.kind = gfw_pkg::KIND_READ;
        row.typed_r.read_value = val;
        row.typed_r.last = 1'b1;
        plan.push_back(row);
    endtask

    task automatic add_cfg(input logic [gfw_pkg::CFG_W-1:0] fl,
                           input logic [gfw_pkg::CFG_W-1:0] rl,
                           input logic [gfw_pkg::PS_W-1:0] ps);
        t_plan_row row;
        row = '{default: '0};
        row.is_cfg = 1'b1;
        row.fl = fl;
        row.rl = rl;
        row.ps = ps;
        plan.push_back(row);
    endtask

    initial begin
        int k;
        int ph;
        int pick;
        int left;
        logic [gfw_pkg::SEQ_W-1:0] cur_seq;
        logic [gfw_pkg::CFG_W-1:0] fl;
        logic [gfw_pkg::CFG_W-1:0] rl;
        logic [gfw_pkg::PS_W-1:0] ps;
        gfw_pkg::t_item it;
        gfw_pkg::t_result none;

        i_rst_n <= 1'b0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= gfw_pkg::REG_FRAME_LENGTH;
        i_cfg_data <= '0;
        start <= 1'b0;
        i_item <= '0;
        errors = 0;
        cycles = 0;
        pushes_sent = 0;
        reads_sent = 0;
        reports_seen = 0;
        words_seen = 0;
        cfg_writes = 0;
        no_gaps = 1'b0;
        none = '0;
        wr_pos = 0;
        last_seq = '0;
        seq_seen = 1'b0;
        frame_len = gfw_pkg::FRAME_LENGTH_RESET;
        ring_len = gfw_pkg::RING_LENGTH_RESET;
        pkt_len = gfw_pkg::PACKET_SAMPLES_RESET;

        // reset defaults: first packet, sign extremes, repeat, backward, adjacent, gaps
        add_push(16'h7FFF, 32'd5, 1'b1, 1'b1);
        add_read(16'd0, 1'b1, 16'h7FFF);
        add_push(16'h8000, 32'd5, 1'b0, 1'b1);
        add_read(16'd1, 1'b1, 16'h8000);
        add_push(16'h1234, 32'd5, 1'b1, 1'b0);
        add_push(16'hFFFF, 32'd3, 1'b1, 1'b0);
        add_push(16'h0001, 32'd4, 1'b1, 1'b0);
        add_push(16'h5A5A, 32'd7, 1'b1, 1'b0);
        add_push(16'hA5A5, 32'd13, 1'b1, 1'b0);
        add_push(16'h0F0F, 32'hFFFF_FFFF, 1'b1, 1'b0);
        add_read(16'd8191, 1'b0, '0);
        // short frames, ring not a multiple of the frame, pad and sample both ending frames
        add_cfg(17'd4, 17'd10, 13'd3);
        add_push(16'h0102, 32'd100, 1'b1, 1'b0);
        add_push(16'h0304, 32'd100, 1'b0, 1'b0);
        add_push(16'h0506, 32'd100, 1'b0, 1'b0);
        add_push(16'h0708, 32'd100, 1'b0, 1'b0);
        add_push(16'h090A, 32'd100, 1'b0, 1'b0);
        add_push(16'h0B0C, 32'd102, 1'b1, 1'b0);
        add_push(16'h0D0E, 32'd102, 1'b0, 1'b0);
        add_push(16'h0F10, 32'd104, 1'b1, 1'b0);
        // zero frame and ring lengths act as one; zero packet samples pad nothing
        add_cfg(17'd0, 17'd0, 13'd0);
        add_push(16'h4321, 32'd200, 1'b1, 1'b0);
        add_read(16'd0, 1'b0, '0);
        // oversized frame and ring lengths clamp to the full store; packet samples at its largest value
        add_cfg(17'h1FFFF, 17'h1FFFF, 13'h1FFF);
        add_push(16'h2468, 32'd202, 1'b1, 1'b0);
        add_push(16'h1357, 32'd212, 1'b1, 1'b0);
        add_read(16'hFFFF, 1'b1, 16'h0000);
        add_read(16'h8000, 1'b0, '0);

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (k = 0; k < plan.size(); k++) begin
            if (plan[k].is_cfg) begin
                await_idle();
                write_regs(plan[k].fl, plan[k].rl, plan[k].ps);
            end else begin
                send_item(plan[k].it, plan[k].typed, plan[k].typed_n, plan[k].typed_r);
            end
        end

        cur_seq = $urandom;
        left = 0;
        for (ph = 0; ph < RANDOM_PHASES; ph++) begin
            fl = gfw_pkg::CFG_W'($urandom_range(1, 40));
            rl = gfw_pkg::CFG_W'($urandom_range(1, 300));
            ps = gfw_pkg::PS_W'($urandom_range(0, 12));
            case (ph)
                1: fl = '0;
                2: rl = '0;
                3: rl = 17'h1FFFF;
                5: ps = 13'h1FFF;
                6: begin
                    fl = 17'd64;
                    rl = 17'd65536;
                end
                7: begin
                    ps = '0;
                    rl = fl;
                end
                default: ;
            endcase
            no_gaps = (ph == 4);
            await_idle();
            write_regs(fl, rl, ps);
            for (k = 0; k < ITEMS_PER_PHASE; k++) begin
                it = '0;
                it.sample = gfw_pkg::SAMPLE_W'($urandom);
                it.read_address = gfw_pkg::ADDR_W'($urandom);
                it.packet_seq = cur_seq;
                if (filled_addrs.size() > 0 && $urandom_range(99) < 20) begin
                    it.operation = gfw_pkg::OP_READ;
                    it.packet_seq = $urandom;
                    it.packet_start = 1'($urandom_range(1));
                    it.read_address = gfw_pkg::ADDR_W'(
                        filled_addrs[$urandom_range(0, filled_addrs.size() - 1)]);
                end else begin
                    it.operation = gfw_pkg::OP_PUSH;
                    if (left == 0) begin
                        left = $urandom_range(1, 6);
                        pick = $urandom_range(99);
                        if (pick < 65) cur_seq = cur_seq + 1;
                        else if (pick < 85) cur_seq = cur_seq + $urandom_range(2, 5);
                        else if (pick < 90) cur_seq = cur_seq;
                        else if (pick < 95) cur_seq = cur_seq - $urandom_range(1, 3);
                        else cur_seq = $urandom;
                        it.packet_seq = cur_seq;
                        it.packet_start = 1'b1;
                    end else if ($urandom_range(99) < 3) begin
                        it.packet_seq = $urandom;
                    end
                    left--;
                end
                send_item(it, 1'b0, 0, none);
            end
        end
        no_gaps = 1'b0;

        await_idle();
        $display("Covered %0d pushes and %0d reads across %0d register writes",
                 pushes_sent, reads_sent, cfg_writes);
        $display("Matched %0d frame reports and %0d read words, %0d mismatches",
                 reports_seen, words_seen, errors);
        if (errors == 0 && owed.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

### sim.f
+incdir+sv
sv/gfw_pkg.sv
sv/gfw_div.sv
sv/gfw_mem.sv
sv/gap_filling_frame_ring_writer_core.sv
sim/gap_filling_frame_ring_writer_core_tb.sv
